// File: design/pds_pkg.sv
// PLL divider solver package: payload types, state encoding, limit constants.
// No dependencies; used by the channel interfaces and the top level.
package pds_pkg;

    typedef struct packed {
        logic [31:0] reference_hz;
        logic [31:0] wanted_hz;
    } pds_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  fb_divider;
        logic [3:0]  ref_divider;
        logic [2:0]  post_one;
        logic [2:0]  post_two;
        logic [29:0] achieved_hz;
    } pds_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_PRE,
        ST_FAC,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_CHECK,
        ST_FINISH
    } pds_state_t;

    localparam logic [1:0] STATUS_SOLVED    = 2'd0;
    localparam logic [1:0] STATUS_BADARG    = 2'd1;
    localparam logic [1:0] STATUS_NOSETTING = 2'd2;

    localparam logic [31:0] PLLIN_MIN_HZ = 32'd5000000;
    localparam logic [31:0] PLLIN_MAX_HZ = 32'd64000000;
    localparam logic [34:0] VCO_LOW_HZ   = 35'd500000000;
    localparam logic [34:0] VCO_HIGH_HZ  = 35'd1600000000;
    localparam logic [31:0] OUT_LIMIT_HZ = 32'd800000000;
    localparam logic [8:0]  FB_LOW       = 9'd16;
    localparam logic [8:0]  FB_HIGH      = 9'd400;
    localparam logic [3:0]  PRE_LOW      = 4'd1;
    localparam logic [3:0]  PRE_HIGH     = 4'd15;
    localparam logic [2:0]  POST_LOW     = 3'd1;
    localparam logic [2:0]  POST_HIGH    = 3'd7;
    localparam logic [3:0]  QUOT_MSB     = 4'd8;

endpackage

// File: design/pds_req_if.sv
// Request channel: valid/ready with reference and wanted frequency payload.
// Depends on pds_pkg.
interface pds_req_if
    import pds_pkg::*;
;
    logic     valid;
    logic     ready;
    pds_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/pds_rsp_if.sv
// Result channel: valid/ready with status and divider payload.
// Depends on pds_pkg.
interface pds_rsp_if
    import pds_pkg::*;
;
    logic     valid;
    logic     ready;
    pds_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/pll_divider_solver_top.sv
// PLL divider solver: sequencer around multipliers and one shift-subtract divider.
// Depends on pds_pkg, pds_req_if, pds_rsp_if.
//
// Usage:
//   req carries one beat of reference_hz and wanted_hz; rsp returns exactly one
//   beat with status, the divider fields and achieved_hz.
//   req.ready is high only while the sequencer is idle; one request is solved
//   at a time.
//   Sequence: zero or out-of-range requests go straight to the result. Otherwise
//   each pre-divider gets an input-range check, and each candidate gets a factor,
//   multiply and quotient-bound step, plus, when the quotient fits 9 bits, 9
//   restoring division steps, one per cycle, and a final check.
//   The result sits in an output register; the next request is taken while it
//   waits. If the receiver stalls, a finished search holds until the register
//   frees.
//   Reset clears the sequencer and drops rsp.valid.
module pll_divider_solver_top
    import pds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pds_req_if.sink   req,
    pds_rsp_if.source rsp
);

    pds_state_t  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    pds_rsp_t    out_data_reg, out_data_next;

    logic [31:0] ref_reg, ref_next;
    logic [31:0] want_reg, want_next;
    logic [3:0]  pre_reg, pre_next;
    logic [2:0]  p1_reg, p1_next;
    logic [2:0]  p2_reg, p2_next;
    logic [9:0]  fac_reg, fac_next;
    logic [39:0] num_reg, num_next;
    logic [39:0] rem_reg, rem_next;
    logic [8:0]  quot_reg, quot_next;
    logic [3:0]  bit_reg, bit_next;
    logic [1:0]  status_reg, status_next;

    logic [31:0] in_lo, in_hi;
    logic [34:0] vco_lo, vco_hi;
    logic        pre_ok, fits, solved, last_pre, out_free;
    logic [39:0] mul_prod;
    logic [40:0] dsh;
    logic        dsub;

    assign in_lo    = PLLIN_MIN_HZ * {28'd0, pre_reg};
    assign in_hi    = PLLIN_MAX_HZ * {28'd0, pre_reg};
    assign vco_lo   = VCO_LOW_HZ * {31'd0, pre_reg};
    assign vco_hi   = VCO_HIGH_HZ * {31'd0, pre_reg};
    assign pre_ok   = (ref_reg >= in_lo) && (ref_reg <= in_hi);
    assign last_pre = (pre_reg == PRE_HIGH);
    assign mul_prod = {10'd0, want_reg[29:0]} * {30'd0, fac_reg};
    assign fits     = {1'b0, num_reg} < {ref_reg, 9'd0};
    assign dsh      = {9'd0, ref_reg} << bit_reg;
    assign dsub     = {1'b0, rem_reg} >= dsh;
    assign solved   = (rem_reg == 40'd0) && (quot_reg >= FB_LOW) && (quot_reg <= FB_HIGH)
                      && (num_reg >= {5'd0, vco_lo}) && (num_reg <= {5'd0, vco_hi});
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (ref_reg == 32'd0 || want_reg == 32'd0 || want_reg > OUT_LIMIT_HZ)
                    state_next = ST_FINISH;
                else
                    state_next = ST_PRE;
            end
            ST_PRE:
            begin
                if (pre_ok)
                    state_next = ST_FAC;
                else if (last_pre)
                    state_next = ST_FINISH;
            end
            ST_FAC:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_CMP;
            ST_CMP,
            ST_CHECK:
            begin
                if (state_reg == ST_CMP && fits)
                    state_next = ST_DIV;
                else if (state_reg == ST_CHECK && solved)
                    state_next = ST_FINISH;
                else if (p1_reg != POST_HIGH || p2_reg != POST_HIGH)
                    state_next = ST_FAC;
                else if (last_pre)
                    state_next = ST_FINISH;
                else
                    state_next = ST_PRE;
            end
            ST_DIV:
            begin
                if (bit_reg == 4'd0)
                    state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ref_next       = ref_reg;
        want_next      = want_reg;
        pre_next       = pre_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        fac_next       = fac_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        bit_next       = bit_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            ST_IDLE:
            begin
                ref_next  = req.data.reference_hz;
                want_next = req.data.wanted_hz;
            end
            ST_START:
            begin
                pre_next    = PRE_LOW;
                p1_next     = POST_LOW;
                p2_next     = POST_LOW;
                status_next = STATUS_NOSETTING;
                if (ref_reg == 32'd0 || want_reg == 32'd0)
                    status_next = STATUS_BADARG;
            end
            ST_PRE:
            begin
                if (!pre_ok && !last_pre)
                    pre_next = pre_reg + 4'd1;
            end
            ST_FAC:   fac_next = {6'd0, pre_reg} * {7'd0, p1_reg} * {7'd0, p2_reg};
            ST_MUL:   num_next = mul_prod;
            ST_CMP,
            ST_CHECK:
            begin
                if (state_reg == ST_CMP && fits)
                begin
                    rem_next  = num_reg;
                    quot_next = 9'd0;
                    bit_next  = QUOT_MSB;
                end
                else if (state_reg == ST_CHECK && solved)
                begin
                    status_next = STATUS_SOLVED;
                end
                else if (p1_reg != POST_HIGH)
                begin
                    p1_next = p1_reg + 3'd1;
                end
                else if (p2_reg != POST_HIGH)
                begin
                    p2_next = p2_reg + 3'd1;
                    p1_next = p2_reg + 3'd1;
                end
                else if (!last_pre)
                begin
                    pre_next = pre_reg + 4'd1;
                    p1_next  = POST_LOW;
                    p2_next  = POST_LOW;
                end
            end
            ST_DIV:
            begin
                if (dsub)
                begin
                    rem_next = rem_reg - dsh[39:0];
                    quot_next[bit_reg] = 1'b1;
                end
                bit_next = bit_reg - 4'd1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.status = status_reg;
                    if (status_reg == STATUS_SOLVED)
                    begin
                        out_data_next.fb_divider  = quot_reg;
                        out_data_next.ref_divider = pre_reg;
                        out_data_next.post_one    = p1_reg;
                        out_data_next.post_two    = p2_reg;
                        out_data_next.achieved_hz = want_reg[29:0];
                    end
                    else
                    begin
                        out_data_next.fb_divider  = 9'd0;
                        out_data_next.ref_divider = 4'd0;
                        out_data_next.post_one    = 3'd0;
                        out_data_next.post_two    = 3'd0;
                        out_data_next.achieved_hz = 30'd0;
                    end
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_reg      <= ref_next;
        want_reg     <= want_next;
        pre_reg      <= pre_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        fac_reg      <= fac_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        bit_reg      <= bit_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_solved_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.status == STATUS_SOLVED |->
            rsp.data.fb_divider >= FB_LOW && rsp.data.fb_divider <= FB_HIGH
            && rsp.data.post_two <= rsp.data.post_one && rsp.data.post_two != 3'd0
            && rsp.data.ref_divider != 4'd0)
        else $error("solved beat carries out-of-range dividers");

    a_unsolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.status != STATUS_SOLVED |->
            rsp.data.fb_divider == 9'd0 && rsp.data.achieved_hz == 30'd0
            && rsp.data.ref_divider == 4'd0)
        else $error("unsolved beat carries nonzero fields");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> {1'b0, rem_reg} < ({9'd0, ref_reg} << (bit_reg + 4'd1)))
        else $error("division remainder out of bound");
`endif

endmodule
